// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the record parser.
// Synthesis builds see empty bodies; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that cond implies prop in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
// Checks that cond implies prop in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== rtl/core/ihex_pkg.sv =====
// Types, codes and helper functions for the Intel HEX record parser.
// Used by ihex_step and intel_hex_record_parser; no dependencies.
`timescale 1ns / 1ps
package ihex_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_COUNT,
    PH_ADDR,
    PH_TYPE,
    PH_DATA,
    PH_CSUM,
    PH_DONE
  } phase_t;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] TYPE_EOF   = 8'h01;

  localparam logic [3:0] DIGITS_COUNT_END = 4'd2;
  localparam logic [3:0] DIGITS_ADDR_END  = 4'd6;
  localparam logic [3:0] DIGITS_HEADER    = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  record_type;
    logic [7:0]  byte_count;
    logic        checksum_ok;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } nibble_t;

  function automatic nibble_t hex_decode(input logic [7:0] c);
    nibble_t n;
    n.valid = 1'b1;
    n.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n.value = 4'(c - 8'h57);
    end else begin
      n.valid = 1'b0;
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/ihex_step.sv =====
// Line state of the parser and the combinational update for one word.
// Depends on ihex_pkg.
`timescale 1ns / 1ps
module ihex_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [7:0]        character,
  input  logic              line_end,
  input  logic              pedantic,
  output logic              res_valid,
  output ihex_pkg::result_t res
);
  import ihex_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] high_r, high_nxt;
  logic       pend_r, pend_nxt;
  logic [3:0] digits_r, digits_nxt;
  logic [7:0] count_r, count_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] index_r, index_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] csum_r, csum_nxt;
  logic       seen_r, seen_nxt;
  logic       colon_r, colon_nxt;
  logic       err_r, err_nxt;

  nibble_t    nib;
  phase_t     eff_phase;
  logic       is_colon;
  logic [3:0] digits_inc;
  logic [7:0] count_sh;
  logic [15:0] addr_sh;
  logic [7:0] type_sh;
  logic [7:0] byte_val;
  logic [7:0] index_inc;
  logic       eof;
  logic       sum_ok;
  logic       reject;

  assign nib        = hex_decode(character);
  assign eff_phase  = (phase_r == PH_START) ? PH_COUNT : phase_r;
  assign is_colon   = (phase_r == PH_START) && (character == COLON_CHAR);
  assign digits_inc = (digits_r == DIGITS_HEADER) ? DIGITS_HEADER : digits_r + 4'd1;
  assign count_sh   = {count_r[3:0], nib.value};
  assign addr_sh    = {addr_r[11:0], nib.value};
  assign type_sh    = {type_r[3:0], nib.value};
  assign byte_val   = {high_r, nib.value};
  assign index_inc  = index_r + 8'd1;
  assign eof        = (digits_r == DIGITS_HEADER) && (type_r == TYPE_EOF);
  assign sum_ok     = eof || (seen_r && (8'(sum_r + csum_r) == 8'd0));
  assign reject     = err_r || (digits_r != DIGITS_HEADER) || (phase_r == PH_DATA) ||
                      (pedantic && (!colon_r || !sum_ok));

  always_comb begin
    phase_nxt = phase_r;
    if (go) begin
      if (line_end) begin
        phase_nxt = PH_START;
      end else if (phase_r != PH_DONE) begin
        if (is_colon) begin
          phase_nxt = PH_COUNT;
        end else if (!nib.valid) begin
          phase_nxt = PH_DONE;
        end else begin
          unique case (eff_phase)
            PH_COUNT: begin
              phase_nxt = (digits_inc == DIGITS_COUNT_END) ? PH_ADDR : PH_COUNT;
            end
            PH_ADDR: begin
              if (digits_inc == DIGITS_ADDR_END) phase_nxt = PH_TYPE;
            end
            PH_TYPE: begin
              if (digits_inc == DIGITS_HEADER) begin
                if (type_sh == TYPE_EOF) phase_nxt = PH_DONE;
                else if (count_r == 8'd0) phase_nxt = PH_CSUM;
                else phase_nxt = PH_DATA;
              end
            end
            PH_DATA: begin
              if (pend_r && index_inc == count_r) phase_nxt = PH_CSUM;
            end
            PH_CSUM: begin
              if (pend_r) phase_nxt = PH_DONE;
            end
            default: phase_nxt = phase_r;
          endcase
        end
      end
    end
  end

  always_comb begin
    high_nxt   = high_r;
    pend_nxt   = pend_r;
    digits_nxt = digits_r;
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    type_nxt   = type_r;
    index_nxt  = index_r;
    sum_nxt    = sum_r;
    csum_nxt   = csum_r;
    seen_nxt   = seen_r;
    colon_nxt  = colon_r;
    err_nxt    = err_r;
    res_valid  = 1'b0;
    res.kind        = KIND_DATA;
    res.address     = addr_r + 16'(index_r);
    res.data_byte   = byte_val;
    res.record_type = type_r;
    res.byte_count  = count_r;
    res.checksum_ok = 1'b0;
    if (go) begin
      if (line_end) begin
        res_valid       = 1'b1;
        res.kind        = reject ? KIND_REJECT : KIND_ACCEPT;
        res.address     = addr_r;
        res.data_byte   = 8'd0;
        res.checksum_ok = sum_ok;
        high_nxt   = 4'd0;
        pend_nxt   = 1'b0;
        digits_nxt = 4'd0;
        count_nxt  = 8'd0;
        addr_nxt   = 16'd0;
        type_nxt   = 8'd0;
        index_nxt  = 8'd0;
        sum_nxt    = 8'd0;
        csum_nxt   = 8'd0;
        seen_nxt   = 1'b0;
        colon_nxt  = 1'b0;
        err_nxt    = 1'b0;
      end else if (phase_r != PH_DONE) begin
        if (is_colon) begin
          colon_nxt = 1'b1;
        end else if (!nib.valid) begin
          if (eff_phase != PH_CSUM) err_nxt = 1'b1;
        end else begin
          digits_nxt = digits_inc;
          case (eff_phase)
            PH_COUNT: begin
              count_nxt = count_sh;
              if (digits_inc == DIGITS_COUNT_END) sum_nxt = sum_r + count_sh;
            end
            PH_ADDR: begin
              addr_nxt = addr_sh;
              if (digits_inc == DIGITS_ADDR_END) begin
                sum_nxt = sum_r + addr_sh[15:8] + addr_sh[7:0];
              end
            end
            PH_TYPE: begin
              type_nxt = type_sh;
              if (digits_inc == DIGITS_HEADER) sum_nxt = sum_r + type_sh;
            end
            default: begin
              if (!pend_r) begin
                high_nxt = nib.value;
                pend_nxt = 1'b1;
              end else begin
                pend_nxt = 1'b0;
                if (eff_phase == PH_DATA) begin
                  res_valid = 1'b1;
                  sum_nxt   = sum_r + byte_val;
                  index_nxt = index_inc;
                end else begin
                  csum_nxt = byte_val;
                  seen_nxt = 1'b1;
                end
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      high_r   <= 4'd0;
      pend_r   <= 1'b0;
      digits_r <= 4'd0;
      count_r  <= 8'd0;
      addr_r   <= 16'd0;
      type_r   <= 8'd0;
      index_r  <= 8'd0;
      sum_r    <= 8'd0;
      csum_r   <= 8'd0;
      seen_r   <= 1'b0;
      colon_r  <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      high_r   <= high_nxt;
      pend_r   <= pend_nxt;
      digits_r <= digits_nxt;
      count_r  <= count_nxt;
      addr_r   <= addr_nxt;
      type_r   <= type_nxt;
      index_r  <= index_nxt;
      sum_r    <= sum_nxt;
      csum_r   <= csum_nxt;
      seen_r   <= seen_nxt;
      colon_r  <= colon_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

// ===== rtl/core/intel_hex_record_parser.sv =====
// Top level of the Intel HEX record parser: input register, output register, config.
// Depends on ihex_pkg, ihex_step and assert_macros.svh.
//
//   Channel  Direction  Carries
//   in_      slave      one character per word, tlast closes the line
//   out_     master     data byte or record summary, tuser gives the kind
//   cfg_     slave      pedantic mode bit
//
// The update logic sits between the input register and the output register, so a result
// word passes through the input register and then the output register; one word is taken
// every cycle while the output is not stalled. The line state updates once per taken word.
// Reset is synchronous and returns the line state to the start of a record.
// A stalled output holds its word and stops the input register behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module intel_hex_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] address, [23:16] data_byte,
                                  // [31:24] record_type, [39:32] byte_count,
                                  // [40] checksum_ok, [47:41] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import ihex_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_char_r;
  logic       in_last_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;
  logic       pedantic_r;
  logic       advance;
  logic       res_valid;
  result_t    res;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  ihex_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (advance),
    .character (in_char_r),
    .line_end  (in_last_r),
    .pedantic  (pedantic_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && res_valid) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pedantic_r  <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) pedantic_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (advance && res_valid) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {7'd0, out_res_r.checksum_ok, out_res_r.byte_count,
                       out_res_r.record_type, out_res_r.data_byte, out_res_r.address};

  `ASSERT_NEXT(a_line_end_summary, clk, rst_n, advance && in_last_r,
               out_valid_r && out_res_r.kind != KIND_DATA)
  `ASSERT_IMPLIES(a_stall_source, clk, rst_n, !in_tready,
                  in_valid_r && out_valid_r && !out_tready)
  `ASSERT_IMPLIES(a_data_no_ok, clk, rst_n, out_valid_r && out_res_r.kind == KIND_DATA,
                  !out_res_r.checksum_ok)

endmodule
